[src/igbt_pkg.sv]
`timescale 1ns / 1ps
// types, constants and helper functions of the iou greedy box tracker
// no dependencies

package igbt_pkg;

  localparam int COORD_W = 12;
  localparam int MUL_W   = 25;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int RECIP10 = 52429;
  localparam int RECIP_SH = 19;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] h;
  } box_t;

  typedef struct packed {
    logic        valid_res;
    logic [7:0]  cls;
    logic [15:0] score;
    box_t        bx;
    logic        from_track;
  } res_t;

  typedef enum logic [13:0] {
    ST_IDLE  = 14'b00000000000001,
    ST_TRK   = 14'b00000000000010,
    ST_SCAN  = 14'b00000000000100,
    ST_MINT  = 14'b00000000001000,
    ST_MAT   = 14'b00000000010000,
    ST_MAD   = 14'b00000000100000,
    ST_MUNI  = 14'b00000001000000,
    ST_MTHR  = 14'b00000010000000,
    ST_MCUR  = 14'b00000100000000,
    ST_MBEST = 14'b00001000000000,
    ST_DEC   = 14'b00010000000000,
    ST_BLEND = 14'b00100000000000,
    ST_CMP   = 14'b01000000000000,
    ST_NEW   = 14'b10000000000000
  } state_t;

  localparam logic CFG_IOU_THRESHOLD = 1'b0;
  localparam logic CFG_MAX_MISSED    = 1'b1;

  function automatic logic [COORD_W:0] overlap(input logic [COORD_W-1:0] a0,
                                               input logic [COORD_W-1:0] al,
                                               input logic [COORD_W-1:0] b0,
                                               input logic [COORD_W-1:0] bl);
    logic [COORD_W:0] lo, hi, ae, be;
    ae = {1'b0, a0} + {1'b0, al};
    be = {1'b0, b0} + {1'b0, bl};
    lo = (a0 > b0) ? {1'b0, a0} : {1'b0, b0};
    hi = (ae < be) ? ae : be;
    return (hi > lo) ? (hi - lo) : '0;
  endfunction

  function automatic logic [15:0] blend_sum(input logic [COORD_W-1:0] o,
                                            input logic [COORD_W-1:0] n);
    return ({1'b0, o, 3'b0} - {4'b0, o}) + {3'b0, n, 1'b0} + {4'b0, n};
  endfunction

endpackage

[src/igbt_mul.sv]
`timescale 1ns / 1ps
// shared multiplier with registered product
// depends on igbt_pkg

module igbt_mul (
  input  logic                          clk,
  input  logic [igbt_pkg::MUL_W-1:0]    a,
  input  logic [igbt_pkg::MUL_W-1:0]    b,
  output logic [igbt_pkg::PROD_W-1:0]   p
);

  logic [igbt_pkg::PROD_W-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= {{igbt_pkg::MUL_W{1'b0}}, a} * {{igbt_pkg::MUL_W{1'b0}}, b};
  end

  assign p = p_r;

endmodule

[src/iou_greedy_box_tracker_top.sv]
`timescale 1ns / 1ps
// top level: frame buffer, track table and sequencer of the tracker
// depends on igbt_pkg and igbt_mul
// detection items are stored while idle; an end of frame ages and matches each track against the open same-class
// detections, blends matched tracks, drops stale ones and adds new tracks, using the single shared multiplier.
// each result leaves in the cycle after the next is known, the last in the cycle after the walk ends.
// synchronous reset empties the track table and frame buffer, thresholds 77 and 5.

module iou_greedy_box_tracker_top #(
  parameter int MAX_TRACKS     = 16,
  parameter int MAX_DETECTIONS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_kind,
  input  logic [7:0]  in_class_id,
  input  logic [15:0] in_score,
  input  logic [11:0] in_box_x,
  input  logic [11:0] in_box_y,
  input  logic [11:0] in_box_width,
  input  logic [11:0] in_box_height,
  output logic        out_valid,
  output logic        out_valid_res,
  output logic [7:0]  out_class,
  output logic [15:0] out_score,
  output logic [11:0] out_x,
  output logic [11:0] out_y,
  output logic [11:0] out_width,
  output logic [11:0] out_height,
  output logic        out_from_track,
  output logic        out_last,
  output logic        out_overflow,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int TCNT_W = $clog2(MAX_TRACKS + 1);
  localparam int DCNT_W = $clog2(MAX_DETECTIONS + 1);
  localparam int TIDX_W = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int DIDX_W = (MAX_DETECTIONS > 1) ? $clog2(MAX_DETECTIONS) : 1;
  localparam int MW = igbt_pkg::MUL_W;
  localparam int PW = igbt_pkg::PROD_W;

  igbt_pkg::state_t state_r;

  igbt_pkg::box_t tb_r [MAX_TRACKS];
  logic [7:0]     tc_r [MAX_TRACKS];
  logic [7:0]     tm_r [MAX_TRACKS];
  igbt_pkg::box_t fb_r [MAX_DETECTIONS];
  logic [7:0]     fc_r [MAX_DETECTIONS];
  logic [15:0]    fs_r [MAX_DETECTIONS];

  logic [TCNT_W-1:0]         tcount_r, t_r, kept_r;
  logic [DCNT_W-1:0]         fcount_r, i_r;
  logic [MAX_DETECTIONS-1:0] matched_r;
  logic                      ovf_r;
  logic [7:0]                thr_r, maxm_r;

  logic [DIDX_W-1:0] best_r;
  logic              found_r;
  logic [23:0]       bi_r;
  logic [MW-1:0]     bu_r;
  logic [12:0]       ox_r, oy_r;
  logic [23:0]       inter_r, at_r;
  logic [MW-1:0]     uni_r;
  logic              thr_ok_r;
  logic [PW-1:0]     lhs_r;
  logic [1:0]        c_r;
  logic              bl_wr_r;

  igbt_pkg::res_t pend_r, out_r;
  logic           pend_v_r, out_v_r, out_last_r, out_ovf_r;

  logic [MW-1:0] mul_a, mul_b;
  logic [PW-1:0] prod;

  logic [TIDX_W-1:0] ti, ki;
  logic [DIDX_W-1:0] di, fi;
  igbt_pkg::box_t    tbox, dbox, bbox;
  logic [11:0]       old_c, new_c;
  logic [15:0]       bsum;
  logic [11:0]       bq;

  assign ti   = t_r[TIDX_W-1:0];
  assign ki   = kept_r[TIDX_W-1:0];
  assign di   = i_r[DIDX_W-1:0];
  assign fi   = fcount_r[DIDX_W-1:0];
  assign tbox = tb_r[ti];
  assign dbox = fb_r[di];
  assign bbox = fb_r[best_r];
  assign bq   = prod[igbt_pkg::RECIP_SH +: 12];

  always_comb begin
    case (c_r)
      2'd0:    begin old_c = tbox.x; new_c = bbox.x; end
      2'd1:    begin old_c = tbox.y; new_c = bbox.y; end
      2'd2:    begin old_c = tbox.w; new_c = bbox.w; end
      default: begin old_c = tbox.h; new_c = bbox.h; end
    endcase
    bsum = igbt_pkg::blend_sum(old_c, new_c);
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      igbt_pkg::ST_MINT: begin mul_a = MW'(ox_r); mul_b = MW'(oy_r); end
      igbt_pkg::ST_MAT:  begin mul_a = MW'(tbox.w); mul_b = MW'(tbox.h); end
      igbt_pkg::ST_MAD:  begin mul_a = MW'(dbox.w); mul_b = MW'(dbox.h); end
      igbt_pkg::ST_MTHR: begin mul_a = MW'(thr_r); mul_b = uni_r; end
      igbt_pkg::ST_MCUR: begin mul_a = MW'(inter_r); mul_b = bu_r; end
      igbt_pkg::ST_MBEST: begin mul_a = MW'(bi_r); mul_b = uni_r; end
      igbt_pkg::ST_BLEND: begin mul_a = MW'(bsum); mul_b = MW'(igbt_pkg::RECIP10); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  igbt_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  logic           new_v;
  igbt_pkg::res_t new_res;
  logic           fin;

  always_comb begin
    new_v   = 1'b0;
    new_res = '0;
    fin     = 1'b0;
    unique case (state_r)
      igbt_pkg::ST_BLEND: begin
        if (bl_wr_r && c_r == 2'd3) begin
          new_v = 1'b1;
          new_res.valid_res  = 1'b1;
          new_res.cls        = tc_r[ti];
          new_res.score      = fs_r[best_r];
          new_res.bx         = tbox;
          new_res.bx.h       = bq;
          new_res.from_track = 1'b1;
        end
      end
      igbt_pkg::ST_NEW: begin
        if (i_r == fcount_r) begin
          fin = 1'b1;
        end else if (!matched_r[di]) begin
          new_v = 1'b1;
          new_res.valid_res  = 1'b1;
          new_res.cls        = fc_r[di];
          new_res.score      = fs_r[di];
          new_res.bx         = dbox;
          new_res.from_track = 1'b0;
        end
      end
      default: begin
        new_v = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= igbt_pkg::ST_IDLE;
      tcount_r   <= '0;
      fcount_r   <= '0;
      matched_r  <= '0;
      ovf_r      <= 1'b0;
      thr_r      <= 8'd77;
      maxm_r     <= 8'd5;
      pend_v_r   <= 1'b0;
      out_v_r    <= 1'b0;
      t_r        <= '0;
      i_r        <= '0;
      kept_r     <= '0;
      c_r        <= '0;
      bl_wr_r    <= 1'b0;
      found_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          igbt_pkg::CFG_IOU_THRESHOLD: thr_r  <= cfg_data;
          igbt_pkg::CFG_MAX_MISSED:    maxm_r <= cfg_data;
          default:                     thr_r  <= thr_r;
        endcase
      end

      // output stage: hold one result back so the final one can carry last
      out_v_r <= (new_v && pend_v_r) || fin;
      if (new_v) begin
        pend_r   <= new_res;
        pend_v_r <= 1'b1;
        if (pend_v_r) begin
          out_r      <= pend_r;
          out_last_r <= 1'b0;
          out_ovf_r  <= 1'b0;
        end
      end else if (fin) begin
        pend_v_r   <= 1'b0;
        out_r      <= pend_v_r ? pend_r : '0;
        out_last_r <= 1'b1;
        out_ovf_r  <= ovf_r;
      end

      unique case (state_r)
        igbt_pkg::ST_IDLE: begin
          if (start) begin
            if (in_kind) begin
              t_r     <= '0;
              state_r <= igbt_pkg::ST_TRK;
            end else if (fcount_r < DCNT_W'(MAX_DETECTIONS)) begin
              fc_r[fi]   <= in_class_id;
              fs_r[fi]   <= in_score;
              fb_r[fi]   <= '{x: in_box_x, y: in_box_y, w: in_box_width, h: in_box_height};
              fcount_r   <= fcount_r + 1'b1;
            end else begin
              ovf_r <= 1'b1;
            end
          end
        end
        igbt_pkg::ST_TRK: begin
          if (t_r == tcount_r) begin
            t_r     <= '0;
            kept_r  <= '0;
            state_r <= igbt_pkg::ST_CMP;
          end else begin
            if (tm_r[ti] != 8'd255) tm_r[ti] <= tm_r[ti] + 8'd1;
            i_r     <= '0;
            found_r <= 1'b0;
            bi_r    <= '0;
            bu_r    <= MW'(1);
            state_r <= igbt_pkg::ST_SCAN;
          end
        end
        igbt_pkg::ST_SCAN: begin
          if (i_r == fcount_r) begin
            if (found_r) begin
              c_r     <= '0;
              bl_wr_r <= 1'b0;
              state_r <= igbt_pkg::ST_BLEND;
            end else begin
              t_r     <= t_r + 1'b1;
              state_r <= igbt_pkg::ST_TRK;
            end
          end else if (matched_r[di] || fc_r[di] != tc_r[ti]) begin
            i_r <= i_r + 1'b1;
          end else begin
            ox_r    <= igbt_pkg::overlap(tbox.x, tbox.w, dbox.x, dbox.w);
            oy_r    <= igbt_pkg::overlap(tbox.y, tbox.h, dbox.y, dbox.h);
            state_r <= igbt_pkg::ST_MINT;
          end
        end
        igbt_pkg::ST_MINT: state_r <= igbt_pkg::ST_MAT;
        igbt_pkg::ST_MAT: begin
          inter_r <= prod[23:0];
          state_r <= igbt_pkg::ST_MAD;
        end
        igbt_pkg::ST_MAD: begin
          at_r    <= prod[23:0];
          state_r <= igbt_pkg::ST_MUNI;
        end
        igbt_pkg::ST_MUNI: begin
          uni_r   <= MW'(at_r) + MW'(prod[23:0]) - MW'(inter_r);
          state_r <= igbt_pkg::ST_MTHR;
        end
        igbt_pkg::ST_MTHR: state_r <= igbt_pkg::ST_MCUR;
        igbt_pkg::ST_MCUR: begin
          thr_ok_r <= PW'({inter_r, 8'b0}) > prod;
          state_r  <= igbt_pkg::ST_MBEST;
        end
        igbt_pkg::ST_MBEST: begin
          lhs_r   <= prod;
          state_r <= igbt_pkg::ST_DEC;
        end
        igbt_pkg::ST_DEC: begin
          if (thr_ok_r && lhs_r > prod) begin
            found_r <= 1'b1;
            best_r  <= di;
            bi_r    <= inter_r;
            bu_r    <= uni_r;
          end
          i_r     <= i_r + 1'b1;
          state_r <= igbt_pkg::ST_SCAN;
        end
        igbt_pkg::ST_BLEND: begin
          bl_wr_r <= !bl_wr_r;
          if (bl_wr_r) begin
            case (c_r)
              2'd0:    tb_r[ti].x <= bq;
              2'd1:    tb_r[ti].y <= bq;
              2'd2:    tb_r[ti].w <= bq;
              default: tb_r[ti].h <= bq;
            endcase
            c_r <= c_r + 2'd1;
            if (c_r == 2'd3) begin
              tm_r[ti]          <= 8'd0;
              matched_r[best_r] <= 1'b1;
              t_r               <= t_r + 1'b1;
              state_r           <= igbt_pkg::ST_TRK;
            end
          end
        end
        igbt_pkg::ST_CMP: begin
          if (t_r == tcount_r) begin
            tcount_r <= kept_r;
            i_r      <= '0;
            state_r  <= igbt_pkg::ST_NEW;
          end else begin
            if (tm_r[ti] <= maxm_r) begin
              tb_r[ki] <= tb_r[ti];
              tc_r[ki] <= tc_r[ti];
              tm_r[ki] <= tm_r[ti];
              kept_r   <= kept_r + 1'b1;
            end
            t_r <= t_r + 1'b1;
          end
        end
        igbt_pkg::ST_NEW: begin
          if (i_r == fcount_r) begin
            fcount_r  <= '0;
            matched_r <= '0;
            ovf_r     <= 1'b0;
            state_r   <= igbt_pkg::ST_IDLE;
          end else begin
            if (!matched_r[di] && tcount_r < TCNT_W'(MAX_TRACKS)) begin
              tb_r[tcount_r[TIDX_W-1:0]] <= dbox;
              tc_r[tcount_r[TIDX_W-1:0]] <= fc_r[di];
              tm_r[tcount_r[TIDX_W-1:0]] <= 8'd0;
              tcount_r <= tcount_r + 1'b1;
            end
            i_r <= i_r + 1'b1;
          end
        end
        default: state_r <= igbt_pkg::ST_IDLE;
      endcase
    end
  end

  assign busy           = (state_r != igbt_pkg::ST_IDLE);
  assign out_valid      = out_v_r;
  assign out_valid_res  = out_r.valid_res;
  assign out_class      = out_r.cls;
  assign out_score      = out_r.score;
  assign out_x          = out_r.bx.x;
  assign out_y          = out_r.bx.y;
  assign out_width      = out_r.bx.w;
  assign out_height     = out_r.bx.h;
  assign out_from_track = out_r.from_track;
  assign out_last       = out_last_r;
  assign out_overflow   = out_ovf_r;

endmodule

[tb/tb_iou_greedy_box_tracker_top.sv]
`timescale 1ns / 1ps
// testbench of the iou greedy box tracker: directed table, then random frames, checked against a built-in
// tracker predictor or the table's own expected results; depends on igbt_pkg and iou_greedy_box_tracker_top

module tb_iou_greedy_box_tracker_top;

  localparam int NTRK = 16;
  localparam int NDET = 16;
  localparam int WD_LIMIT = 40000;
  localparam logic KIND_DET = 1'b0;
  localparam logic KIND_EOF = 1'b1;

  typedef struct {
    logic           kind;
    logic [7:0]     cls;
    logic [15:0]    score;
    igbt_pkg::box_t bx;
  } det_item_t;

  typedef struct {
    logic           valid_res;
    logic [7:0]     cls;
    logic [15:0]    score;
    igbt_pkg::box_t bx;
    logic           from_track;
    logic           last;
    logic           overflow;
  } frame_res_t;

  typedef struct {
    det_item_t  it;
    bit         typed;
    frame_res_t res;
  } tab_row_t;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  logic        in_kind = 0;
  logic [7:0]  in_class_id = '0;
  logic [15:0] in_score = '0;
  logic [11:0] in_box_x = '0, in_box_y = '0, in_box_width = '0, in_box_height = '0;
  logic        out_valid, out_valid_res, out_from_track, out_last, out_overflow;
  logic [7:0]  out_class;
  logic [15:0] out_score;
  logic [11:0] out_x, out_y, out_width, out_height;
  logic        cfg_we = 0;
  logic        cfg_index = igbt_pkg::CFG_IOU_THRESHOLD;
  logic [7:0]  cfg_data = '0;

  iou_greedy_box_tracker_top dut (.*);

  always #5 clk = ~clk;

  // tracker predictor state
  igbt_pkg::box_t trk_box [NTRK];
  logic [7:0]     trk_cls [NTRK];
  int             trk_miss [NTRK];
  int             trk_n;
  igbt_pkg::box_t frm_box [NDET];
  logic [7:0]     frm_cls [NDET];
  logic [15:0]    frm_score [NDET];
  int             frm_n;
  bit [NDET-1:0]  frm_taken;
  bit             frm_ovf;
  int             thr_q8;
  int             miss_lim;

  frame_res_t  frame_res_q [$];
  tab_row_t    tab [$];
  int          n_items, n_results, n_matched, n_frames, n_ovf_frames, n_errors;
  bit          idling_on;
  int          wd_cnt;

  function automatic longint unsigned span_ovl(int a0, int al, int b0, int bl);
    int lo, hi;
    lo = (a0 > b0) ? a0 : b0;
    hi = (a0 + al < b0 + bl) ? a0 + al : b0 + bl;
    return (hi > lo) ? longint'(hi - lo) : 0;
  endfunction

  function automatic int smooth(int o, int n);
    return (7 * o + 3 * n) / 10;
  endfunction

  task automatic push_res(logic vr, logic [7:0] c, logic [15:0] s, igbt_pkg::box_t b,
                          logic ft);
    frame_res_t r;
    r.valid_res = vr; r.cls = c; r.score = s; r.bx = b; r.from_track = ft;
    r.last = 0; r.overflow = 0;
    frame_res_q = {frame_res_q, r};
  endtask

  task automatic predict_item(det_item_t it);
    longint unsigned ia, ua, bi, bu, aa, ab;
    int best, kept;
    igbt_pkg::box_t tb, db;
    if (it.kind == KIND_DET) begin
      if (frm_n >= NDET) begin
        frm_ovf = 1;
      end else begin
        frm_box[frm_n] = it.bx; frm_cls[frm_n] = it.cls; frm_score[frm_n] = it.score;
        frm_n++;
      end
      return;
    end
    n_frames++;
    if (frm_ovf) n_ovf_frames++;
    for (int t = 0; t < trk_n; t++) begin
      best = -1; bi = 0; bu = 1;
      if (trk_miss[t] < 255) trk_miss[t]++;
      tb = trk_box[t];
      for (int i = 0; i < frm_n; i++) begin
        if (frm_taken[i] || frm_cls[i] != trk_cls[t]) continue;
        db = frm_box[i];
        ia = span_ovl(int'(tb.x), int'(tb.w), int'(db.x), int'(db.w)) *
             span_ovl(int'(tb.y), int'(tb.h), int'(db.y), int'(db.h));
        aa = longint'(tb.w) * longint'(tb.h);
        ab = longint'(db.w) * longint'(db.h);
        ua = aa + ab - ia;
        if (ia * 256 > longint'(thr_q8) * ua && ia * bu > bi * ua) begin
          best = i; bi = ia; bu = ua;
        end
      end
      if (best >= 0) begin
        db = frm_box[best];
        tb.x = 12'(smooth(int'(tb.x), int'(db.x)));
        tb.y = 12'(smooth(int'(tb.y), int'(db.y)));
        tb.w = 12'(smooth(int'(tb.w), int'(db.w)));
        tb.h = 12'(smooth(int'(tb.h), int'(db.h)));
        trk_box[t] = tb;
        trk_miss[t] = 0;
        frm_taken[best] = 1;
        n_matched++;
        push_res(1'b1, trk_cls[t], frm_score[best], tb, 1'b1);
      end
    end
    kept = 0;
    for (int t = 0; t < trk_n; t++) begin
      if (trk_miss[t] > miss_lim) continue;
      trk_box[kept] = trk_box[t]; trk_cls[kept] = trk_cls[t]; trk_miss[kept] = trk_miss[t];
      kept++;
    end
    trk_n = kept;
    for (int i = 0; i < frm_n; i++) begin
      if (frm_taken[i]) continue;
      if (trk_n < NTRK) begin
        trk_box[trk_n] = frm_box[i]; trk_cls[trk_n] = frm_cls[i]; trk_miss[trk_n] = 0;
        trk_n++;
      end
      push_res(1'b1, frm_cls[i], frm_score[i], frm_box[i], 1'b0);
    end
    if (frame_res_q.size() == 0 || frame_res_q[$].last)
      push_res(1'b0, 8'd0, 16'd0, '0, 1'b0);
    frame_res_q[$].last = 1;
    frame_res_q[$].overflow = frm_ovf;
    frm_n = 0; frm_taken = '0; frm_ovf = 0;
  endtask

  // sender: drives start and the item with nonblocking assignments, with random gaps while idling_on is set
  task automatic send(det_item_t it, bit typed, frame_res_t te);
    int sz;
    if (idling_on && $urandom_range(99) < 17) begin
      start <= 0;
      @(posedge clk);
      while ($urandom_range(99) < 17) @(posedge clk);
    end
    start <= 1;
    in_kind <= it.kind; in_class_id <= it.cls; in_score <= it.score;
    in_box_x <= it.bx.x; in_box_y <= it.bx.y;
    in_box_width <= it.bx.w; in_box_height <= it.bx.h;
    do @(posedge clk); while (busy);
    n_items++;
    sz = frame_res_q.size();
    predict_item(it);
    if (typed) begin
      while (frame_res_q.size() > sz) void'(frame_res_q.pop_back());
      frame_res_q = {frame_res_q, te};
    end
  endtask

  task automatic send_plain(det_item_t it);
    frame_res_t none;
    none = '{default: '0};
    send(it, 0, none);
  endtask

  task automatic drain;
    start <= 0;
    while (frame_res_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [7:0] val);
    drain();
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == igbt_pkg::CFG_IOU_THRESHOLD) thr_q8 = int'(val); else miss_lim = int'(val);
    @(posedge clk);
  endtask

  function automatic int clamp12(int v);
    return (v < 0) ? 0 : (v > 4095) ? 4095 : v;
  endfunction

  task automatic rand_frame;
    det_item_t d;
    int n, k;
    n = ($urandom_range(99) < 8) ? 17 + int'($urandom_range(3)) : int'($urandom_range(6));
    for (int i = 0; i < n; i++) begin
      d.kind = KIND_DET;
      d.score = 16'($urandom());
      if (trk_n > 0 && $urandom_range(99) < 60) begin
        k = int'($urandom_range(trk_n - 1));
        d.cls = trk_cls[k];
        d.bx.x = 12'(clamp12(int'(trk_box[k].x) + int'($urandom_range(16)) - 8));
        d.bx.y = 12'(clamp12(int'(trk_box[k].y) + int'($urandom_range(16)) - 8));
        d.bx.w = 12'(clamp12(int'(trk_box[k].w) + int'($urandom_range(16)) - 8));
        d.bx.h = 12'(clamp12(int'(trk_box[k].h) + int'($urandom_range(16)) - 8));
      end else begin
        d.cls = ($urandom_range(9) == 0) ? 8'($urandom()) : 8'($urandom_range(3));
        d.bx.x = 12'($urandom()); d.bx.y = 12'($urandom());
        if ($urandom_range(9) == 0) begin
          d.bx.w = 12'($urandom()); d.bx.h = 12'($urandom());
        end else begin
          d.bx.w = 12'($urandom_range(200)); d.bx.h = 12'($urandom_range(200));
        end
      end
      send_plain(d);
    end
    d.kind = KIND_EOF;
    d.cls = 8'($urandom()); d.score = 16'($urandom());
    d.bx = igbt_pkg::box_t'(48'({$urandom(), $urandom()}));
    send_plain(d);
  endtask

  task automatic add_row(logic kind, logic [7:0] c, logic [15:0] s, igbt_pkg::box_t b,
                         bit typed, frame_res_t r);
    tab_row_t row;
    row.it.kind = kind; row.it.cls = c; row.it.score = s; row.it.bx = b;
    row.typed = typed; row.res = r;
    tab = {tab, row};
  endtask

  // result checker
  always @(posedge clk) begin
    frame_res_t e;
    if (rst_n && out_valid) begin
      n_results++;
      if (frame_res_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result at %0t", $realtime);
      end else begin
        e = frame_res_q.pop_front();
        if (out_valid_res !== e.valid_res || out_class !== e.cls || out_score !== e.score ||
            out_x !== e.bx.x || out_y !== e.bx.y || out_width !== e.bx.w ||
            out_height !== e.bx.h || out_from_track !== e.from_track ||
            out_last !== e.last || out_overflow !== e.overflow) begin
          n_errors++;
          if (n_errors <= 10) begin
            $display("mismatch at %0t: exp v%0b c%0d s%0d box %0d %0d %0d %0d t%0b l%0b o%0b",
                     $realtime, e.valid_res, e.cls, e.score, e.bx.x, e.bx.y, e.bx.w, e.bx.h,
                     e.from_track, e.last, e.overflow);
            $display("  got v%0b c%0d s%0d box %0d %0d %0d %0d t%0b l%0b o%0b",
                     out_valid_res, out_class, out_score, out_x, out_y, out_width,
                     out_height, out_from_track, out_last, out_overflow);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) wd_cnt <= 0;
    else wd_cnt <= wd_cnt + 1;
    if (wd_cnt > WD_LIMIT) begin
      $display("timeout: no activity for %0d cycles", WD_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    frame_res_t r, none;
    igbt_pkg::box_t bmax, b0;
    det_item_t d;
    trk_n = 0; frm_n = 0; frm_taken = '0; frm_ovf = 0;
    thr_q8 = 77; miss_lim = 5;
    n_items = 0; n_results = 0; n_matched = 0; n_frames = 0; n_ovf_frames = 0;
    n_errors = 0; idling_on = 1; wd_cnt = 0;
    none = '{default: '0};
    bmax = '{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF};
    b0 = '0;

    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed table
    r = none; r.last = 1;
    add_row(KIND_EOF, 8'hFF, 16'hFFFF, bmax, 1, r);
    add_row(KIND_DET, 8'hFF, 16'hFFFF, bmax, 0, none);
    r = '{1, 8'hFF, 16'hFFFF, bmax, 0, 1, 0};
    add_row(KIND_EOF, 0, 0, b0, 1, r);
    add_row(KIND_DET, 8'hFF, 16'h1234, '{12'hFF0, 12'hFF0, 12'h00F, 12'h00F}, 0, none);
    add_row(KIND_DET, 8'hFF, 16'h0001, bmax, 0, none);
    add_row(KIND_EOF, 0, 0, b0, 0, none);
    add_row(KIND_DET, 8'h00, 16'h0000, b0, 0, none);
    add_row(KIND_DET, 8'h00, 16'h8000, '{12'd0, 12'd0, 12'd0, 12'd10}, 0, none);
    add_row(KIND_EOF, 0, 0, b0, 0, none);
    add_row(KIND_DET, 8'h00, 16'h0000, b0, 0, none);
    add_row(KIND_DET, 8'h01, 16'h5555, '{12'd100, 12'd100, 12'd50, 12'd50}, 0, none);
    add_row(KIND_DET, 8'h01, 16'hAAAA, '{12'd100, 12'd100, 12'd50, 12'd50}, 0, none);
    add_row(KIND_EOF, 0, 0, b0, 0, none);
    add_row(KIND_DET, 8'h01, 16'h0F0F, '{12'd104, 12'd100, 12'd50, 12'd50}, 0, none);
    add_row(KIND_DET, 8'h01, 16'hF0F0, '{12'd96, 12'd100, 12'd50, 12'd50}, 0, none);
    add_row(KIND_DET, 8'h01, 16'h00FF, '{12'd300, 12'd300, 12'd50, 12'd50}, 0, none);
    add_row(KIND_EOF, 0, 0, b0, 0, none);
    add_row(KIND_EOF, 0, 0, b0, 0, none);
    foreach (tab[i]) send(tab[i].it, tab[i].typed, tab[i].res);

    // threshold extremes and immediate track removal
    write_reg(igbt_pkg::CFG_IOU_THRESHOLD, 8'd0);
    write_reg(igbt_pkg::CFG_MAX_MISSED, 8'd0);
    repeat (3) rand_frame();
    write_reg(igbt_pkg::CFG_IOU_THRESHOLD, 8'd255);
    repeat (2) rand_frame();

    // top miss limit keeps unmatched tracks, then a low limit drops them
    write_reg(igbt_pkg::CFG_IOU_THRESHOLD, 8'($urandom()));
    write_reg(igbt_pkg::CFG_MAX_MISSED, 8'd255);
    rand_frame();
    d.kind = KIND_EOF; d.cls = 0; d.score = 0; d.bx = b0;
    repeat (4) send_plain(d);
    write_reg(igbt_pkg::CFG_MAX_MISSED, 8'd1);
    send_plain(d);

    // back to default settings, a stretch without sender gaps first
    write_reg(igbt_pkg::CFG_IOU_THRESHOLD, 8'd77);
    write_reg(igbt_pkg::CFG_MAX_MISSED, 8'd5);
    idling_on = 0;
    repeat (3) rand_frame();
    idling_on = 1;
    for (int p = 0; p < 9; p++) begin
      if (p == 4) begin
        write_reg(igbt_pkg::CFG_IOU_THRESHOLD, 8'($urandom_range(40, 160)));
        write_reg(igbt_pkg::CFG_MAX_MISSED, 8'($urandom_range(0, 3)));
      end
      rand_frame();
    end

    start <= 0;
    while (frame_res_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("covered %0d items in %0d frames (%0d with dropped detections), %0d results",
             n_items, n_frames, n_ovf_frames, n_results);
    $display("track matches predicted: %0d, mismatches: %0d", n_matched, n_errors);
    if (n_errors == 0 && frame_res_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
src/igbt_pkg.sv
src/igbt_mul.sv
src/iou_greedy_box_tracker_top.sv
tb/tb_iou_greedy_box_tracker_top.sv
